// File: rtl/imusc_pkg.sv
package imusc_pkg;

   localparam int AXES      = 3;
   localparam int RAW_W     = 16;
   localparam int CNT_W     = RAW_W + 1;
   localparam int SENS_W    = 23;
   localparam int PROD_W    = CNT_W + SENS_W;
   localparam int REG_W     = 18;
   localparam int OUT_W     = 32;
   localparam int SAT_IN_W  = 80;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 2 * AXES * RAW_W;
   localparam int RSP_DATA_W = 2 * AXES * OUT_W;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_BIAS_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_BIAS_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_BIAS_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GYRO_OFFSET_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GYRO_OFFSET_Z = 3'd4;

   typedef logic signed [REG_W-1:0] reg_type;
   typedef logic signed [OUT_W-1:0] word_type;

   typedef struct packed {
      reg_type accel_bias_x;
      reg_type accel_bias_y;
      reg_type accel_bias_z;
      reg_type gyro_offset_x;
      reg_type gyro_offset_z;
   } cfg_type;

   localparam reg_type RST_ACCEL_BIAS_X  = 18'sd7357;
   localparam reg_type RST_ACCEL_BIAS_Y  = -18'sd7262;
   localparam reg_type RST_ACCEL_BIAS_Z  = 18'sd21686;
   localparam reg_type RST_GYRO_OFFSET_X = 18'sd3277;
   localparam reg_type RST_GYRO_OFFSET_Z = 18'sd1049;

   // Sensitivities with 32 fraction bits: m/s^2 per count and rad/s per count.
   localparam logic signed [SENS_W-1:0] ACCEL_GAIN = 23'sd2569274;
   localparam logic signed [SENS_W-1:0] GYRO_GAIN  = 23'sd1311823;

   // Correction matrix in millionths, row major.
   localparam int MAT_MICRO [9] = '{997626, -4172, 953,
                                    -4172, 991214, -4644,
                                    953, -4644, 991372};

   localparam logic signed [SAT_IN_W-1:0] SAT_HI = 80'sd2147483647;
   localparam logic signed [SAT_IN_W-1:0] SAT_LO = -80'sd2147483648;

   // Matrix coefficient with cfb fraction bits, rounded half away from zero.
   function automatic longint imusc_coef(input int k, input int cfb);
      longint c;
      longint a;
      longint q;
      c = longint'(MAT_MICRO[k]);
      a = (c < 0) ? -c : c;
      q = (a * (longint'(1) << cfb) + 64'sd500000) / 64'sd1000000;
      return (c < 0) ? -q : q;
   endfunction

   function automatic word_type sat_word(input logic signed [SAT_IN_W-1:0] v);
      word_type r;
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/imusc_scale.sv
module imusc_scale import imusc_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int D_W       = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_cal,
   input  logic [AXES-1:0][RAW_W-1:0]    in_accel_raw,
   input  logic [AXES-1:0][RAW_W-1:0]    in_gyro_raw,
   input  cfg_type                       cfg,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_cal,
   output logic [AXES-1:0][D_W-1:0]      out_diff,
   output logic [AXES-1:0][OUT_W-1:0]    out_accel,
   output logic [AXES-1:0][OUT_W-1:0]    out_rate
);

   localparam int SH  = 32 - FRAC_BITS;
   localparam int A_W = PROD_W + 1 - SH;
   localparam logic signed [PROD_W:0] HALF = (PROD_W + 1)'(64'sd1) << (SH - 1);

   logic                           va_ff, vb_ff;
   logic                           en_a, en_b;
   logic                           cal_a_ff, cal_b_ff;
   logic signed [CNT_W-1:0]        cnt [2*AXES];
   logic signed [PROD_W-1:0]       prod_in [2*AXES];
   logic signed [PROD_W-1:0]       prod_ff [2*AXES];
   logic signed [PROD_W:0]         rnd [2*AXES];
   logic signed [A_W-1:0]          scaled [2*AXES];
   logic signed [D_W-1:0]          bias [AXES];
   logic signed [D_W-1:0]          rdiff [AXES];
   logic [AXES-1:0][D_W-1:0]       diff_in, diff_ff;
   logic [AXES-1:0][OUT_W-1:0]     accel_in, accel_ff;
   logic [AXES-1:0][OUT_W-1:0]     rate_in, rate_ff;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   // Axis remap: board x is minus raw y, board y is raw x.
   always_comb begin
      cnt[0] = -CNT_W'($signed(in_accel_raw[1]));
      cnt[1] = CNT_W'($signed(in_accel_raw[0]));
      cnt[2] = CNT_W'($signed(in_accel_raw[2]));
      cnt[3] = -CNT_W'($signed(in_gyro_raw[1]));
      cnt[4] = CNT_W'($signed(in_gyro_raw[0]));
      cnt[5] = CNT_W'($signed(in_gyro_raw[2]));
      for (int k = 0; k < 2*AXES; k++) begin
         prod_in[k] = PROD_W'(cnt[k]) * PROD_W'((k < AXES) ? ACCEL_GAIN : GYRO_GAIN);
      end
   end

   always_comb begin
      bias[0] = D_W'(cfg.accel_bias_x);
      bias[1] = D_W'(cfg.accel_bias_y);
      bias[2] = D_W'(cfg.accel_bias_z);
      for (int k = 0; k < 2*AXES; k++) begin
         rnd[k]    = (PROD_W + 1)'(prod_ff[k]) + HALF;
         scaled[k] = $signed(rnd[k][PROD_W:SH]);
      end
      for (int i = 0; i < AXES; i++) begin
         diff_in[i]  = D_W'(scaled[i]) - bias[i];
         accel_in[i] = sat_word(SAT_IN_W'(scaled[i]));
      end
      rdiff[0] = D_W'(scaled[3]) - D_W'(cfg.gyro_offset_x);
      rdiff[1] = D_W'(scaled[4]);
      rdiff[2] = D_W'(scaled[5]) - D_W'(cfg.gyro_offset_z);
      for (int i = 0; i < AXES; i++) begin
         rate_in[i] = sat_word(SAT_IN_W'(rdiff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         cal_a_ff <= in_cal;
         for (int k = 0; k < 2*AXES; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      if (en_b) begin
         cal_b_ff <= cal_a_ff;
         diff_ff  <= diff_in;
         accel_ff <= accel_in;
         rate_ff  <= rate_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_cal   = cal_b_ff;
   assign out_diff  = diff_ff;
   assign out_accel = accel_ff;
   assign out_rate  = rate_ff;

endmodule

// File: rtl/imusc_matrix.sv
module imusc_matrix import imusc_pkg::*; #(
   parameter int D_W            = 25,
   parameter int COEF_FRAC_BITS = 20,
   parameter int S_W            = 49
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_cal,
   input  logic [AXES-1:0][D_W-1:0]      in_diff,
   input  logic [AXES-1:0][OUT_W-1:0]    in_accel,
   input  logic [AXES-1:0][OUT_W-1:0]    in_rate,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_cal,
   output logic [AXES-1:0][S_W-1:0]      out_sum,
   output logic [AXES-1:0][OUT_W-1:0]    out_accel,
   output logic [AXES-1:0][OUT_W-1:0]    out_rate
);

   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int P_W    = S_W - 2;
   localparam logic signed [COEF_W-1:0] COEF [9] = '{
      COEF_W'(imusc_coef(0, COEF_FRAC_BITS)), COEF_W'(imusc_coef(1, COEF_FRAC_BITS)),
      COEF_W'(imusc_coef(2, COEF_FRAC_BITS)), COEF_W'(imusc_coef(3, COEF_FRAC_BITS)),
      COEF_W'(imusc_coef(4, COEF_FRAC_BITS)), COEF_W'(imusc_coef(5, COEF_FRAC_BITS)),
      COEF_W'(imusc_coef(6, COEF_FRAC_BITS)), COEF_W'(imusc_coef(7, COEF_FRAC_BITS)),
      COEF_W'(imusc_coef(8, COEF_FRAC_BITS))};

   logic                         vc_ff, vd_ff;
   logic                         en_c, en_d;
   logic                         cal_c_ff, cal_d_ff;
   logic signed [P_W-1:0]        p_in [AXES*AXES];
   logic signed [P_W-1:0]        p_ff [AXES*AXES];
   logic [AXES-1:0][S_W-1:0]     sum_in, sum_ff;
   logic [AXES-1:0][OUT_W-1:0]   accel_c_ff, accel_d_ff;
   logic [AXES-1:0][OUT_W-1:0]   rate_c_ff, rate_d_ff;

   assign en_d     = !vd_ff || out_ready;
   assign en_c     = !vc_ff || en_d;
   assign in_ready = en_c;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            p_in[i*AXES + j] = P_W'(COEF[i*AXES + j]) * P_W'($signed(in_diff[j]));
         end
      end
      for (int i = 0; i < AXES; i++) begin
         sum_in[i] = S_W'(p_ff[i*AXES]) + S_W'(p_ff[i*AXES + 1]) + S_W'(p_ff[i*AXES + 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (en_c) begin
            vc_ff <= in_valid;
         end
         if (en_d) begin
            vd_ff <= vc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         cal_c_ff   <= in_cal;
         accel_c_ff <= in_accel;
         rate_c_ff  <= in_rate;
         for (int k = 0; k < AXES*AXES; k++) begin
            p_ff[k] <= p_in[k];
         end
      end
      if (en_d) begin
         cal_d_ff   <= cal_c_ff;
         accel_d_ff <= accel_c_ff;
         rate_d_ff  <= rate_c_ff;
         sum_ff     <= sum_in;
      end
   end

   assign out_valid = vd_ff;
   assign out_cal   = cal_d_ff;
   assign out_sum   = sum_ff;
   assign out_accel = accel_d_ff;
   assign out_rate  = rate_d_ff;

endmodule

// File: rtl/imusc_output.sv
module imusc_output import imusc_pkg::*; #(
   parameter int COEF_FRAC_BITS = 20,
   parameter int S_W            = 49
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_cal,
   input  logic [AXES-1:0][S_W-1:0]      in_sum,
   input  logic [AXES-1:0][OUT_W-1:0]    in_accel,
   input  logic [AXES-1:0][OUT_W-1:0]    in_rate,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [RSP_DATA_W-1:0]         out_data
);

   localparam int M_W = S_W + 1 - COEF_FRAC_BITS;
   localparam logic signed [S_W:0] HALF = (S_W + 1)'(64'sd1) << (COEF_FRAC_BITS - 1);

   logic                          ve_ff;
   logic                          en_e;
   logic signed [S_W:0]           rnd [AXES];
   logic signed [M_W-1:0]         shifted [AXES];
   logic [2*AXES-1:0][OUT_W-1:0]  data_in, data_ff;

   assign en_e     = !ve_ff || out_ready;
   assign in_ready = en_e;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         rnd[i]     = (S_W + 1)'($signed(in_sum[i])) + HALF;
         shifted[i] = $signed(rnd[i][S_W:COEF_FRAC_BITS]);
         data_in[i] = in_cal ? sat_word(SAT_IN_W'(shifted[i])) : in_accel[i];
         data_in[AXES + i] = in_rate[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en_e) begin
         ve_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = ve_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/imu_sample_calibration.sv
// Channel  Direction  Ports                        Contents
// req      in         req_tvalid/tready/tdata/tuser  one sample set per transaction
// rsp      out        rsp_tvalid/tready/tdata        accel (calibrated if tuser) and rate
// csr      in         csr_wen/csr_index/csr_wdata    bias and offset registers
//
// One transaction is accepted per cycle while req_tready is high; its result passes
// through five register stages: sensitivity multiply, rounding and offsets, matrix
// multiply, row sums, final rounding into the output register.
// Reset clears all valid bits and reloads the bias and offset registers.
// A stalled output holds its data; bubbles in the pipeline still fill while it waits.
module imu_sample_calibration import imusc_pkg::*; #(
   parameter int FRAC_BITS      = 16,
   parameter int COEF_FRAC_BITS = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // accel_raw_x, accel_raw_y, accel_raw_z, gyro_raw_x, gyro_raw_y, gyro_raw_z
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // calibrate
   input  logic [0:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [REG_W-1:0]        csr_wdata
);

   localparam int SH  = 32 - FRAC_BITS;
   localparam int A_W = PROD_W + 1 - SH;
   localparam int D_W = ((A_W > REG_W) ? A_W : REG_W) + 1;
   localparam int S_W = D_W + COEF_FRAC_BITS + 4;

   cfg_type                      cfg_ff;
   logic                         sc_valid, sc_ready, sc_cal;
   logic [AXES-1:0][D_W-1:0]     sc_diff;
   logic [AXES-1:0][OUT_W-1:0]   sc_accel, sc_rate;
   logic                         mx_valid, mx_ready, mx_cal;
   logic [AXES-1:0][S_W-1:0]     mx_sum;
   logic [AXES-1:0][OUT_W-1:0]   mx_accel, mx_rate;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_bias_x  <= RST_ACCEL_BIAS_X;
         cfg_ff.accel_bias_y  <= RST_ACCEL_BIAS_Y;
         cfg_ff.accel_bias_z  <= RST_ACCEL_BIAS_Z;
         cfg_ff.gyro_offset_x <= RST_GYRO_OFFSET_X;
         cfg_ff.gyro_offset_z <= RST_GYRO_OFFSET_Z;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_ACCEL_BIAS_X:  cfg_ff.accel_bias_x  <= csr_wdata;
            REG_ACCEL_BIAS_Y:  cfg_ff.accel_bias_y  <= csr_wdata;
            REG_ACCEL_BIAS_Z:  cfg_ff.accel_bias_z  <= csr_wdata;
            REG_GYRO_OFFSET_X: cfg_ff.gyro_offset_x <= csr_wdata;
            REG_GYRO_OFFSET_Z: cfg_ff.gyro_offset_z <= csr_wdata;
            default: ;
         endcase
      end
   end

   imusc_scale #(
      .FRAC_BITS (FRAC_BITS),
      .D_W       (D_W)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_cal       (req_tuser[0]),
      .in_accel_raw (req_tdata[AXES*RAW_W-1:0]),
      .in_gyro_raw  (req_tdata[REQ_DATA_W-1:AXES*RAW_W]),
      .cfg          (cfg_ff),
      .out_valid    (sc_valid),
      .out_ready    (sc_ready),
      .out_cal      (sc_cal),
      .out_diff     (sc_diff),
      .out_accel    (sc_accel),
      .out_rate     (sc_rate)
   );

   imusc_matrix #(
      .D_W            (D_W),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .S_W            (S_W)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sc_valid),
      .in_ready  (sc_ready),
      .in_cal    (sc_cal),
      .in_diff   (sc_diff),
      .in_accel  (sc_accel),
      .in_rate   (sc_rate),
      .out_valid (mx_valid),
      .out_ready (mx_ready),
      .out_cal   (mx_cal),
      .out_sum   (mx_sum),
      .out_accel (mx_accel),
      .out_rate  (mx_rate)
   );

   imusc_output #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .S_W            (S_W)
   ) u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mx_valid),
      .in_ready  (mx_ready),
      .in_cal    (mx_cal),
      .in_sum    (mx_sum),
      .in_accel  (mx_accel),
      .in_rate   (mx_rate),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// File: rtl/imusc_checker.sv
module imusc_checker import imusc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int DEPTH = 5;

   logic [2:0] cnt_ff, cnt_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Number of transactions accepted but not yet delivered.
   always_comb begin
      cnt_in = cnt_ff;
      if (req_xfer && !rsp_xfer) begin
         cnt_in = cnt_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != 3'd0)
      else $error("result presented with no transaction in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(DEPTH))
      else $error("more transactions in flight than pipeline stages");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind imu_sample_calibration imusc_checker u_checker (.*);
